>>> hw/rtl/assert_macros.svh
// Concurrent assertion helpers. Both forms sample on clk_i. The reset form
// is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_RST(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

>>> hw/rtl/ffwq_pkg.sv
`timescale 1ns / 1ps
package ffwq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LIST_LIMIT  = (MAX_RESULTS < QUEUE_DEPTH) ? MAX_RESULTS : QUEUE_DEPTH;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEAT   = 2'd1,
    OP_LIST   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_ADDED      = 3'd0,
    ST_DUPLICATE  = 3'd1,
    ST_FULL       = 3'd2,
    ST_SEATED     = 3'd3,
    ST_EMPTY      = 3'd4,
    ST_NONE_FITS  = 3'd5,
    ST_LIST_ENTRY = 3'd6,
    ST_LIST_EMPTY = 3'd7
  } status_e;

  // One stored reservation: the name in three words and the party size.
  typedef struct packed {
    logic [63:0] words_a;
    logic [63:0] words_b;
    logic [31:0] words_c;
    logic [7:0]  party;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Request from the sequencer to the entry memory.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

>>> hw/rtl/ffwq_if.sv
`timescale 1ns / 1ps
// Request channel: one operation on the queue per transfer.
interface ffwq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  size_value;
  logic [63:0] key_bytes_a;
  logic [63:0] key_bytes_b;
  logic [31:0] key_bytes_c;

  modport source (
    output valid, opcode, size_value, key_bytes_a, key_bytes_b, key_bytes_c,
    input  ready
  );
  modport sink (
    input  valid, opcode, size_value, key_bytes_a, key_bytes_b, key_bytes_c,
    output ready
  );
endinterface

// Response channel: one reported entry or status per transfer.
interface ffwq_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] out_bytes_a;
  logic [63:0] out_bytes_b;
  logic [31:0] out_bytes_c;
  logic [7:0]  out_party;
  logic        last;

  modport source (
    output valid, status, out_bytes_a, out_bytes_b, out_bytes_c, out_party, last,
    input  ready
  );
  modport sink (
    input  valid, status, out_bytes_a, out_bytes_b, out_bytes_c, out_party, last,
    output ready
  );
endinterface

>>> hw/rtl/ffwq_ram.sv
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM, one write and one registered read port.
module ffwq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds when no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> hw/rtl/ffwq_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Sequencer: scans, appends, compacts and lists the entry memory, and owns
// the response register.
module ffwq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  ffwq_req_if.sink          req_i,
  ffwq_rsp_if.source        rsp_o,
  output ffwq_pkg::mem_req_t mem_req_o,
  input  ffwq_pkg::entry_t  mem_rdata_i
);
  import ffwq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_EMIT  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_LIST  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] occ_q, occ_d;
  logic [CNT_W-1:0] addr_q, addr_d;
  logic             rvld_q, rvld_d;
  logic [IDX_W-1:0] ridx_q, ridx_d;
  logic             is_ins_q, is_ins_d;
  entry_t           key_q, key_d;
  entry_t           hold_q, hold_d;
  status_e          status_q, status_d;
  logic             out_valid_q, out_valid_d;
  status_e          out_status_q, out_status_d;
  entry_t           out_entry_q, out_entry_d;
  logic             out_last_q, out_last_d;

  logic             req_accept;
  logic             out_free;
  logic             key_eq;
  logic             party_fit;
  logic             hit;
  logic             issue;
  logic             load;
  logic             list_last;
  logic [CNT_W-1:0] lim;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_accept  = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign key_eq    = (mem_rdata_i.words_a == key_q.words_a) &&
                     (mem_rdata_i.words_b == key_q.words_b) &&
                     (mem_rdata_i.words_c == key_q.words_c);
  assign party_fit = (mem_rdata_i.party <= key_q.party);
  assign hit       = rvld_q && (is_ins_q ? key_eq : party_fit);

  assign lim       = (occ_q > CNT_W'(LIST_LIMIT)) ? CNT_W'(LIST_LIMIT) : occ_q;
  assign list_last = ((CNT_W'(ridx_q) + CNT_W'(1)) == lim);

  always_comb begin
    state_d      = state_q;
    occ_d        = occ_q;
    addr_d       = addr_q;
    rvld_d       = rvld_q;
    ridx_d       = ridx_q;
    is_ins_d     = is_ins_q;
    key_d        = key_q;
    hold_d       = hold_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_entry_d  = out_entry_q;
    out_last_d   = out_last_q;
    mem_req_o    = '0;
    issue        = 1'b0;
    load         = 1'b0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_accept) begin
          key_d    = '{words_a: req_i.key_bytes_a, words_b: req_i.key_bytes_b,
                       words_c: req_i.key_bytes_c, party: req_i.size_value};
          is_ins_d = (req_i.opcode == OP_INSERT);
          addr_d   = '0;
          rvld_d   = 1'b0;
          unique case (op_e'(req_i.opcode))
            OP_INSERT, OP_SEAT: begin
              state_d = S_SCAN;
            end
            OP_LIST: begin
              if (occ_q == '0) begin
                hold_d   = '0;
                status_d = ST_LIST_EMPTY;
                state_d  = S_EMIT;
              end else begin
                state_d = S_LIST;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        // One read per cycle; the compare sees the entry in the cycle after its read.
        issue           = (addr_q < occ_q);
        mem_req_o.re    = issue;
        mem_req_o.raddr = addr_q[IDX_W-1:0];
        rvld_d          = issue;
        if (issue) begin
          ridx_d = addr_q[IDX_W-1:0];
          addr_d = addr_q + CNT_W'(1);
        end
        if (hit) begin
          hold_d   = mem_rdata_i;
          status_d = is_ins_q ? ST_DUPLICATE : ST_SEATED;
          addr_d   = CNT_W'(ridx_q) + CNT_W'(1);
          rvld_d   = 1'b0;
          state_d  = S_EMIT;
        end else if (!rvld_q && !issue) begin
          if (is_ins_q) begin
            hold_d = key_q;
            if (occ_q == CNT_W'(QUEUE_DEPTH)) begin
              status_d = ST_FULL;
            end else begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = occ_q[IDX_W-1:0];
              mem_req_o.wdata = key_q;
              occ_d           = occ_q + CNT_W'(1);
              status_d        = ST_ADDED;
            end
          end else begin
            hold_d   = '0;
            status_d = (occ_q == '0) ? ST_EMPTY : ST_NONE_FITS;
          end
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_entry_d  = hold_q;
          out_last_d   = 1'b1;
          rvld_d       = 1'b0;
          state_d      = (status_q == ST_SEATED) ? S_SHIFT : S_IDLE;
        end
      end

      S_SHIFT: begin
        // Move every entry behind the removed one down by a slot.
        issue           = (addr_q < occ_q);
        mem_req_o.re    = issue;
        mem_req_o.raddr = addr_q[IDX_W-1:0];
        rvld_d          = issue;
        if (issue) begin
          ridx_d = addr_q[IDX_W-1:0];
          addr_d = addr_q + CNT_W'(1);
        end
        if (rvld_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = ridx_q - IDX_W'(1);
          mem_req_o.wdata = mem_rdata_i;
        end
        if (!issue && !rvld_q) begin
          occ_d   = occ_q - CNT_W'(1);
          state_d = S_IDLE;
        end
      end

      S_LIST: begin
        // The read data stays on the memory output until the response
        // register can take it.
        load            = rvld_q && out_free;
        issue           = (addr_q < lim) && (!rvld_q || load);
        mem_req_o.re    = issue;
        mem_req_o.raddr = addr_q[IDX_W-1:0];
        rvld_d          = issue || (rvld_q && !load);
        if (issue) begin
          ridx_d = addr_q[IDX_W-1:0];
          addr_d = addr_q + CNT_W'(1);
        end
        if (load) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_LIST_ENTRY;
          out_entry_d  = mem_rdata_i;
          out_last_d   = list_last;
          if (list_last) begin
            rvld_d  = 1'b0;
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      rvld_q      <= rvld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q       <= addr_d;
    ridx_q       <= ridx_d;
    is_ins_q     <= is_ins_d;
    key_q        <= key_d;
    hold_q       <= hold_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_entry_q  <= out_entry_d;
    out_last_q   <= out_last_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.out_bytes_a = out_entry_q.words_a;
  assign rsp_o.out_bytes_b = out_entry_q.words_b;
  assign rsp_o.out_bytes_c = out_entry_q.words_c;
  assign rsp_o.out_party   = out_entry_q.party;
  assign rsp_o.last        = out_last_q;

  `ASSERT_ALWAYS(a_occ_bound, !rst_ni || (occ_q <= CNT_W'(QUEUE_DEPTH)), "occupancy above queue depth")
  `ASSERT_RST(a_write_state, mem_req_o.we |-> (state_q == S_SCAN || state_q == S_SHIFT), "memory write outside scan or shift")
  `ASSERT_RST(a_shift_addr, (state_q == S_SHIFT && mem_req_o.we) |-> (CNT_W'(mem_req_o.waddr) < occ_q), "compaction write beyond occupancy")
  `ASSERT_RST(a_shift_dec, (state_q == S_SHIFT && state_d == S_IDLE) |=> (occ_q == $past(occ_q) - CNT_W'(1)), "seat did not remove one entry")
  `ASSERT_RST(a_op_leaves_idle, (req_accept && req_i.opcode != OP_INSERT + 2'd3) |=> (state_q != S_IDLE), "valid request left sequencer idle")

endmodule

>>> hw/rtl/first_fit_waiting_queue.sv
`timescale 1ns / 1ps
// Channel   Role     Transfer carries
// -------   ------   -----------------------------------------------------
// req_i     sink     opcode, size_value, key_bytes_a/b/c
// rsp_o     source   status, out_bytes_a/b/c, out_party, last
//
// Insert and seat read one entry a cycle: the response follows a scan of all
// occupied slots, or of the slots up to the first that matches. A seat then
// closes the gap by moving every later entry down a slot. List answers once a
// cycle while rsp_o is ready. Reset clears the occupancy count and control
// state, not the memory. A request is taken only while the sequencer is idle;
// a stalled rsp_o holds it.
module first_fit_waiting_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffwq_req_if.sink   req_i,
  ffwq_rsp_if.source rsp_o
);
  import ffwq_pkg::*;

  mem_req_t mem_req;
  entry_t   mem_rdata;

  // Sequencer: decodes each request and walks the queue in the memory.
  ffwq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // All entries live in one memory word each, oldest at address zero.
  ffwq_ram #(
    .Width (ENTRY_W),
    .Depth (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule

>>> sim/first_fit_waiting_queue_tb.sv
`timescale 1ns / 1ps
module first_fit_waiting_queue_tb;
  import ffwq_pkg::*;

  // The opcode value that the block must swallow without producing a transfer.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int POOL_SIZE    = 12;   // names reused so that duplicates show up
  localparam int PHASE_ITEMS  = 25;   // counted requests per random phase
  localparam int HOLD_CYCLES  = 300;  // long response back-pressure stretch
  localparam int DRAIN_CYCLES = 64;   // quiet time after the last reply
  localparam int STALL_LIMIT  = 4000; // cycles without any transfer

  localparam entry_t BLANK = '0;

  // One expected response transfer.
  typedef struct {
    status_e status;
    entry_t  body;
    logic    fin;
  } reply_t;

  // One row of the directed table. A pinned row carries a hand-written reply
  // that replaces the predicted one; it is used only for single-reply rows.
  typedef struct {
    logic [1:0] op;
    entry_t     body;
    int         copies;
    bit         fixed;
    reply_t     want;
  } stim_row_t;

  bit   clk_i;
  logic rst_ni;

  ffwq_req_if req_if ();
  ffwq_rsp_if rsp_if ();

  first_fit_waiting_queue dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Shadow copy of the waiting queue: slot 0 is the oldest reservation.
  entry_t shadow_slots [QUEUE_DEPTH];
  int     shadow_fill;

  // Replies that the block still owes, oldest first.
  reply_t awaited_replies [$];

  entry_t name_pool [POOL_SIZE];

  // Information handed from the request driver to the monitor.
  bit     offer_fixed;
  reply_t offer_want;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_asked;
  int hold_granted;
  int hold_left;
  int idle_run;
  int error_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic entry_t name_entry(logic [63:0] a, logic [63:0] b, logic [31:0] c,
                                        logic [7:0] party);
    entry_t e;
    e.words_a = a;
    e.words_b = b;
    e.words_c = c;
    e.party   = party;
    return e;
  endfunction

  function automatic reply_t make_reply(status_e st, entry_t body, logic fin);
    reply_t r;
    r.status = st;
    r.body   = body;
    r.fin    = fin;
    return r;
  endfunction

  function automatic stim_row_t stim_row(logic [1:0] op, entry_t body, int copies = 1);
    stim_row_t r;
    r.op     = op;
    r.body   = body;
    r.copies = copies;
    r.fixed  = 1'b0;
    r.want   = make_reply(ST_ADDED, BLANK, 1'b0);
    return r;
  endfunction

  function automatic stim_row_t pinned(stim_row_t r, status_e st, entry_t body);
    r.fixed = 1'b1;
    r.want  = make_reply(st, body, 1'b1);
    return r;
  endfunction

  function automatic entry_t fresh_name();
    return name_entry({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 8'd0);
  endfunction

  // Works out the replies that one accepted request causes and applies the
  // request to the shadow queue.
  task automatic predict_waitlist(input logic [1:0] op, input entry_t req);
    int hit;
    int pos;
    int cnt;
    hit = -1;
    pos = -1;
    case (op_e'(op))
      OP_INSERT: begin
        // The duplicate check wins over the full check.
        for (int i = 0; i < shadow_fill; i++) begin
          if (hit < 0 && shadow_slots[i].words_a == req.words_a &&
              shadow_slots[i].words_b == req.words_b &&
              shadow_slots[i].words_c == req.words_c) begin
            hit = i;
          end
        end
        if (hit >= 0) begin
          awaited_replies.push_back(make_reply(ST_DUPLICATE, shadow_slots[hit], 1'b1));
        end else if (shadow_fill >= QUEUE_DEPTH) begin
          awaited_replies.push_back(make_reply(ST_FULL, req, 1'b1));
        end else begin
          shadow_slots[shadow_fill] = req;
          shadow_fill++;
          awaited_replies.push_back(make_reply(ST_ADDED, req, 1'b1));
        end
      end
      OP_SEAT: begin
        if (shadow_fill == 0) begin
          awaited_replies.push_back(make_reply(ST_EMPTY, BLANK, 1'b1));
        end else begin
          // First fit: the oldest party that the free table can hold.
          for (int i = 0; i < shadow_fill; i++) begin
            if (pos < 0 && shadow_slots[i].party <= req.party) begin
              pos = i;
            end
          end
          if (pos < 0) begin
            awaited_replies.push_back(make_reply(ST_NONE_FITS, BLANK, 1'b1));
          end else begin
            awaited_replies.push_back(make_reply(ST_SEATED, shadow_slots[pos], 1'b1));
            for (int j = pos; j + 1 < shadow_fill; j++) begin
              shadow_slots[j] = shadow_slots[j + 1];
            end
            shadow_fill--;
          end
        end
      end
      OP_LIST: begin
        if (shadow_fill == 0) begin
          awaited_replies.push_back(make_reply(ST_LIST_EMPTY, BLANK, 1'b1));
        end else begin
          cnt = (shadow_fill > MAX_RESULTS) ? MAX_RESULTS : shadow_fill;
          for (int i = 0; i < cnt; i++) begin
            awaited_replies.push_back(make_reply(ST_LIST_ENTRY, shadow_slots[i],
                                                 (i + 1 == cnt)));
          end
        end
      end
      default: begin
        // Unused opcode: no reply and no change.
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    error_count++;
    $display("%0t ns: mismatch in %s: expected %h, got %h", $time, what, want, got);
  endtask

  // Monitor: compares each response transfer with the oldest awaited reply,
  // then predicts the replies of a request accepted at the same edge. A reply
  // can never belong to the request accepted at the very same edge, so the
  // check comes first.
  always @(posedge clk_i) begin
    reply_t w;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch("reply with nothing awaited, status", 64'd0,
                          {61'd0, rsp_if.status});
        end else begin
          w = awaited_replies.pop_front();
          if (rsp_if.status !== w.status)
            report_mismatch("status", {61'd0, w.status}, {61'd0, rsp_if.status});
          if (rsp_if.out_bytes_a !== w.body.words_a)
            report_mismatch("out_bytes_a", w.body.words_a, rsp_if.out_bytes_a);
          if (rsp_if.out_bytes_b !== w.body.words_b)
            report_mismatch("out_bytes_b", w.body.words_b, rsp_if.out_bytes_b);
          if (rsp_if.out_bytes_c !== w.body.words_c)
            report_mismatch("out_bytes_c", {32'd0, w.body.words_c}, {32'd0, rsp_if.out_bytes_c});
          if (rsp_if.out_party !== w.body.party)
            report_mismatch("out_party", {56'd0, w.body.party}, {56'd0, rsp_if.out_party});
          if (rsp_if.last !== w.fin)
            report_mismatch("last", {63'd0, w.fin}, {63'd0, rsp_if.last});
        end
      end
      if (req_if.valid && req_if.ready) begin
        predict_waitlist(req_if.opcode, name_entry(req_if.key_bytes_a, req_if.key_bytes_b,
                                                   req_if.key_bytes_c, req_if.size_value));
        if (offer_fixed) begin
          void'(awaited_replies.pop_back());
          awaited_replies.push_back(offer_want);
        end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
  end

  // Watchdog: a run that stops moving ends here as a failure.
  initial begin
    idle_run = 0;
    while (idle_run < STALL_LIMIT) @(posedge clk_i);
    $display("first_fit_waiting_queue_tb: done, errors");
    $finish;
  end

  // Response side. Either a long hold-off requested by the stimulus, counted
  // here in cycles, or random stalls at the rate of the current phase.
  initial begin
    rsp_if.ready = 1'b0;
    hold_granted = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        rsp_if.ready = 1'b0;
        hold_left--;
      end else if (hold_asked != hold_granted) begin
        hold_granted = hold_asked;
        hold_left    = HOLD_CYCLES - 1;
        rsp_if.ready = 1'b0;
      end else begin
        rsp_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Presents one request, with random idle cycles ahead of it, and returns at
  // the falling edge after its transfer. Called only at a falling edge.
  task automatic offer_request(input stim_row_t row);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       = 1'b1;
    req_if.opcode      = row.op;
    req_if.size_value  = row.body.party;
    req_if.key_bytes_a = row.body.words_a;
    req_if.key_bytes_b = row.body.words_b;
    req_if.key_bytes_c = row.body.words_c;
    offer_fixed        = row.fixed;
    offer_want         = row.want;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Random request: mostly names from the pool so that duplicates and
  // repeat visits happen, small party and table sizes half of the time so
  // that first fit has real choices, and now and then the unused opcode.
  function automatic stim_row_t random_row(int insert_pct);
    int     pick;
    int     src;
    entry_t nm;
    logic [1:0] op;
    pick = $urandom_range(0, 99);
    src  = $urandom_range(0, 9);
    if (src < 6) begin
      nm = name_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else if (src == 6) begin
      // Same as a pooled name except for one word.
      nm = name_pool[$urandom_range(0, POOL_SIZE - 1)];
      case ($urandom_range(0, 2))
        0:       nm.words_a = {$urandom, $urandom};
        1:       nm.words_b = {$urandom, $urandom};
        default: nm.words_c = $urandom;
      endcase
    end else begin
      nm = fresh_name();
    end
    nm.party = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 12))
                                           : 8'($urandom_range(0, 255));
    if (pick < 4) begin
      op = OP_UNUSED;
    end else if (pick < 14) begin
      op = OP_LIST;
    end else if (pick < 14 + insert_pct) begin
      op = OP_INSERT;
    end else begin
      op = OP_SEAT;
    end
    return stim_row(op, nm);
  endfunction

  initial begin
    stim_row_t directed_rows [$];
    stim_row_t row;
    entry_t    e_ones;
    entry_t    e_x;
    entry_t    e_y;
    int        counted;
    int        insert_pct;

    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.opcode      = OP_INSERT;
    req_if.size_value  = 8'd0;
    req_if.key_bytes_a = 64'd0;
    req_if.key_bytes_b = 64'd0;
    req_if.key_bytes_c = 32'd0;
    offer_fixed        = 1'b0;
    offer_want         = make_reply(ST_ADDED, BLANK, 1'b0);
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_asked         = 0;
    error_count        = 0;
    shadow_fill        = 0;

    foreach (name_pool[i]) name_pool[i] = fresh_name();

    e_ones = name_entry('1, '1, '1, 8'd255);
    e_x    = name_entry(64'h0000_0000_0041_4c41, 64'd0, 32'd0, 8'd5);
    e_y    = name_entry(64'h6f6e_6e61_6d6e_6172, 64'h0000_0000_0000_0067, 32'd0, 8'd6);

    // Directed part: reset state first, then the sole-entry removal and its
    // tail pointer, field extremes, names that differ in one word only, the
    // first-fit corner with a zero size, a full queue and a full listing.
    directed_rows.push_back(pinned(stim_row(OP_LIST, BLANK), ST_LIST_EMPTY, BLANK));
    directed_rows.push_back(pinned(stim_row(OP_SEAT, name_entry(0, 0, 0, 8'd255)),
                                   ST_EMPTY, BLANK));
    directed_rows.push_back(stim_row(OP_UNUSED, name_entry(64'hA5A5_A5A5_A5A5_A5A5,
                                     64'h5A5A_5A5A_5A5A_5A5A, 32'hC3C3_C3C3, 8'h96)));
    directed_rows.push_back(pinned(stim_row(OP_INSERT, e_x), ST_ADDED, e_x));
    directed_rows.push_back(pinned(stim_row(OP_SEAT, name_entry(0, 0, 0, 8'd5)),
                                   ST_SEATED, e_x));
    directed_rows.push_back(pinned(stim_row(OP_INSERT, e_y), ST_ADDED, e_y));
    // With the tail pointer fixed up, the listing shows only the new entry.
    directed_rows.push_back(pinned(stim_row(OP_LIST, BLANK), ST_LIST_ENTRY, e_y));
    directed_rows.push_back(pinned(stim_row(OP_SEAT, name_entry(0, 0, 0, 8'd6)),
                                   ST_SEATED, e_y));
    directed_rows.push_back(pinned(stim_row(OP_INSERT, e_ones), ST_ADDED, e_ones));
    directed_rows.push_back(pinned(stim_row(OP_INSERT, BLANK), ST_ADDED, BLANK));
    directed_rows.push_back(pinned(stim_row(OP_INSERT, name_entry('1, '1, '1, 8'd7)),
                                   ST_DUPLICATE, e_ones));
    directed_rows.push_back(stim_row(OP_INSERT, name_entry(0, 0, 32'd1, 8'd3)));
    directed_rows.push_back(stim_row(OP_INSERT, name_entry(64'd1, 0, 0, 8'd200)));
    directed_rows.push_back(stim_row(OP_INSERT,
                                     name_entry(0, 64'h8000_0000_0000_0000, 0, 8'd4)));
    // A zero-size table still seats the zero-size party.
    directed_rows.push_back(stim_row(OP_SEAT, name_entry(0, 0, 0, 8'd0)));
    directed_rows.push_back(pinned(stim_row(OP_SEAT, name_entry(0, 0, 0, 8'd2)),
                                   ST_NONE_FITS, BLANK));
    directed_rows.push_back(stim_row(OP_LIST, BLANK));
    // Four entries are left; twelve more fill the queue.
    directed_rows.push_back(stim_row(OP_INSERT, name_entry(64'h0123_4567_89AB_CDE0,
                                     64'h0F1E_2D3C_4B5A_6978, 32'h1357_9BDF, 8'd10), 12));
    row = stim_row(OP_INSERT, name_entry(64'h5A5A_0000_FFFF_1234, 64'd77, 32'd9, 8'd9));
    directed_rows.push_back(pinned(row, ST_FULL, row.body));
    // The duplicate check comes ahead of the full check.
    directed_rows.push_back(pinned(stim_row(OP_INSERT, name_entry(0, 0, 32'd1, 8'd1)),
                                   ST_DUPLICATE, name_entry(0, 0, 32'd1, 8'd3)));
    directed_rows.push_back(stim_row(OP_LIST, BLANK));
    directed_rows.push_back(stim_row(OP_SEAT, name_entry(0, 0, 0, 8'd255)));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].copies; k++) begin
        row = directed_rows[r];
        row.body.words_a = row.body.words_a + 64'(k);
        offer_request(row);
      end
    end

    // Random phases: no idling, sender idle, receiver stalling, both. Before
    // each phase the sender pauses until every awaited reply has arrived.
    for (int phase = 0; phase < 4; phase++) begin
      req_if.valid = 1'b0;
      while (awaited_replies.size() != 0) @(posedge clk_i);
      @(negedge clk_i);
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  insert_pct = 60; end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  insert_pct = 40; end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; insert_pct = 55; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; insert_pct = 45; end
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        // Early in the first phase the response side holds off for a long
        // stretch while requests keep coming, so the input backs up.
        if (phase == 0 && counted == 6) hold_asked = 1;
        row = random_row(insert_pct);
        offer_request(row);
        if (row.op != OP_UNUSED) counted++;
      end
    end

    req_if.valid = 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("first_fit_waiting_queue_tb: done, clean");
    end else begin
      $display("first_fit_waiting_queue_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> first_fit_waiting_queue.f
+incdir+hw/rtl
hw/rtl/ffwq_pkg.sv
hw/rtl/ffwq_if.sv
hw/rtl/ffwq_ram.sv
hw/rtl/ffwq_ctrl.sv
hw/rtl/first_fit_waiting_queue.sv
sim/first_fit_waiting_queue_tb.sv
